### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-consequent implication, sampled on the rising clock edge.
`define VIP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define VIP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/vip_pkg.sv
// ----------------------------------------------------------------------------
// vip_pkg
// Types and constants of the identification header parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vip_pkg;

  localparam int unsigned OUT_TDATA_W = 184;
  localparam int unsigned OUT_TUSER_W = 2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_MAGIC = 3'd1,
    ST_SHORT     = 3'd2,
    ST_VERSION   = 3'd3,
    ST_CHANNELS  = 3'd4,
    ST_RATE      = 3'd5,
    ST_BLOCKSIZE = 3'd6,
    ST_FRAMING   = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_IDENT   = 2'd1,
    KIND_COMMENT = 2'd2,
    KIND_SETUP   = 2'd3
  } kind_e;

  localparam logic [7:0] TYPE_IDENT   = 8'h01;
  localparam logic [7:0] TYPE_COMMENT = 8'h03;
  localparam logic [7:0] TYPE_SETUP   = 8'h05;

  localparam logic [3:0] BLOCK_EXP_MIN = 4'd6;
  localparam logic [3:0] BLOCK_EXP_MAX = 4'd13;

  // Byte positions
  localparam logic [4:0] POS_MAGIC_END = 5'd6;
  localparam logic [4:0] POS_VER_LO    = 5'd7;
  localparam logic [4:0] POS_VER_HI    = 5'd10;
  localparam logic [4:0] POS_CHAN      = 5'd11;
  localparam logic [4:0] POS_RATE_LO   = 5'd12;
  localparam logic [4:0] POS_RATE_HI   = 5'd15;
  localparam logic [4:0] POS_BR_LO     = 5'd16;
  localparam logic [4:0] POS_BR_HI     = 5'd27;
  localparam logic [4:0] POS_BLOCK     = 5'd28;
  localparam logic [4:0] POS_FRAMING   = 5'd29;
  localparam logic [4:0] POS_MAX       = 5'd31;
  // A full identification header is 30 bytes, so its last byte sits here
  localparam logic [4:0] POS_ID_LAST   = 5'd29;

  // "vorbis"
  localparam logic [5:0][7:0] MAGIC = {8'h73, 8'h69, 8'h62, 8'h72, 8'h6F, 8'h76};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [4:0]       pos;
    logic [7:0]       type_byte;
    logic             magic_ok;
    logic [31:0]      version;
    logic [7:0]       channels;
    logic [31:0]      rate;
    logic [2:0][31:0] bitrate;
    logic [7:0]       block_byte;
    logic             framing;
  } fields_t;

  localparam fields_t FIELDS_RST = '{
    pos:        5'd0,
    type_byte:  8'd0,
    magic_ok:   1'b1,
    version:    32'd0,
    channels:   8'd0,
    rate:       32'd0,
    bitrate:    '0,
    block_byte: 8'd0,
    framing:    1'b0
  };

endpackage

### rtl/vip_in_stage.sv
// ----------------------------------------------------------------------------
// vip_in_stage
// Input register for incoming packet bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vip_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [7:0]     s_axis_tdata,   // [7:0] data_byte
  input  logic           s_axis_tlast,
  input  logic           take_i,
  output logic           valid_o,
  output vip_pkg::beat_t beat_o
);

  logic           valid_q;
  vip_pkg::beat_t beat_q;

  // Register is free when empty or drained this cycle
  assign s_axis_tready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      beat_q.data <= s_axis_tdata;
      beat_q.last <= s_axis_tlast;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

### rtl/vip_fields.sv
// ----------------------------------------------------------------------------
// vip_fields
// Byte position, magic match and identification field registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vip_fields (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  vip_pkg::beat_t   beat_i,
  output vip_pkg::fields_t fields_o
);

  vip_pkg::fields_t fields_q;
  vip_pkg::fields_t fields_d;
  vip_pkg::fields_t upd;
  logic [4:0]       pos;
  logic [4:0]       off;
  logic [2:0]       magic_idx;

  assign pos = fields_q.pos;

  // Fields as they stand once the current byte is folded in; pos stays at
  // the position of the current byte.
  always_comb begin
    upd       = fields_q;
    off       = pos - vip_pkg::POS_VER_LO;
    magic_idx = 3'(pos - 5'd1);
    case (pos) inside
      5'd0: begin
        upd.type_byte = beat_i.data;
      end
      [5'd1:vip_pkg::POS_MAGIC_END]: begin
        if (beat_i.data != vip_pkg::MAGIC[magic_idx]) begin
          upd.magic_ok = 1'b0;
        end
      end
      [vip_pkg::POS_VER_LO:vip_pkg::POS_VER_HI]: begin
        upd.version[8*off[1:0] +: 8] = beat_i.data;
      end
      vip_pkg::POS_CHAN: begin
        upd.channels = beat_i.data;
      end
      [vip_pkg::POS_RATE_LO:vip_pkg::POS_RATE_HI]: begin
        upd.rate[8*pos[1:0] +: 8] = beat_i.data;
      end
      [vip_pkg::POS_BR_LO:vip_pkg::POS_BR_HI]: begin
        // word index is (pos - 16) / 4, lane is pos mod 4
        upd.bitrate[pos[3:2]][8*pos[1:0] +: 8] = beat_i.data;
      end
      vip_pkg::POS_BLOCK: begin
        upd.block_byte = beat_i.data;
      end
      vip_pkg::POS_FRAMING: begin
        upd.framing = beat_i.data[0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    fields_d = upd;
    if (pos != vip_pkg::POS_MAX) begin
      fields_d.pos = pos + 5'd1;
    end
    if (beat_i.last) begin
      fields_d = vip_pkg::FIELDS_RST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fields_q <= vip_pkg::FIELDS_RST;
    end else if (step_i) begin
      fields_q <= fields_d;
    end
  end

  assign fields_o = upd;

endmodule

### rtl/vip_result.sv
// ----------------------------------------------------------------------------
// vip_result
// Header checks and the result register on the output stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vip_result (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  vip_pkg::fields_t                fields_i,
  output logic                            free_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [2:0] status, [34:3] stream_version, [42:35] channels,
  // [74:43] audio_rate, [106:75] bitrate_max, [138:107] bitrate_nom,
  // [170:139] bitrate_min, [174:171] block_exp_small,
  // [178:175] block_exp_large, [183:179] zero
  output logic [vip_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [vip_pkg::OUT_TUSER_W-1:0] m_axis_tuser    // [1:0] packet_kind
);

  logic                            valid_q;
  logic [vip_pkg::OUT_TDATA_W-1:0] tdata_q;
  logic [vip_pkg::OUT_TDATA_W-1:0] tdata_d;
  vip_pkg::kind_e                  kind_q;
  vip_pkg::kind_e                  kind;
  vip_pkg::status_e                status;
  logic [3:0]                      bs;
  logic [3:0]                      bl;
  logic                            bs_bad;
  logic                            bl_bad;
  logic                            is_header;

  assign bs = fields_i.block_byte[3:0];
  assign bl = fields_i.block_byte[7:4];
  assign bs_bad = (bs < vip_pkg::BLOCK_EXP_MIN) || (bs > vip_pkg::BLOCK_EXP_MAX);
  assign bl_bad = (bl < vip_pkg::BLOCK_EXP_MIN) || (bl > vip_pkg::BLOCK_EXP_MAX);
  assign is_header = (fields_i.pos >= vip_pkg::POS_MAGIC_END) && fields_i.magic_ok;

  always_comb begin
    kind = vip_pkg::KIND_NONE;
    if (is_header) begin
      case (fields_i.type_byte)
        vip_pkg::TYPE_IDENT:   kind = vip_pkg::KIND_IDENT;
        vip_pkg::TYPE_COMMENT: kind = vip_pkg::KIND_COMMENT;
        vip_pkg::TYPE_SETUP:   kind = vip_pkg::KIND_SETUP;
        default:               kind = vip_pkg::KIND_NONE;
      endcase
    end
  end

  always_comb begin
    tdata_d = '0;
    if (kind != vip_pkg::KIND_IDENT) begin
      status = vip_pkg::ST_BAD_MAGIC;
    end else if (fields_i.pos < vip_pkg::POS_ID_LAST) begin
      status = vip_pkg::ST_SHORT;
    end else begin
      if (fields_i.version != 32'd0) begin
        status = vip_pkg::ST_VERSION;
      end else if (fields_i.channels == 8'd0) begin
        status = vip_pkg::ST_CHANNELS;
      end else if (fields_i.rate == 32'd0) begin
        status = vip_pkg::ST_RATE;
      end else if (bs_bad || bl_bad || (bs > bl)) begin
        status = vip_pkg::ST_BLOCKSIZE;
      end else if (!fields_i.framing) begin
        status = vip_pkg::ST_FRAMING;
      end else begin
        status = vip_pkg::ST_OK;
      end
      tdata_d[34:3]    = fields_i.version;
      tdata_d[42:35]   = fields_i.channels;
      tdata_d[74:43]   = fields_i.rate;
      tdata_d[106:75]  = fields_i.bitrate[0];
      tdata_d[138:107] = fields_i.bitrate[1];
      tdata_d[170:139] = fields_i.bitrate[2];
      tdata_d[174:171] = bs;
      tdata_d[178:175] = bl;
    end
    tdata_d[2:0] = status;
  end

  assign free_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tdata_q <= tdata_d;
      kind_q  <= kind;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = kind_q;

endmodule

### rtl/vorbis_id_header_parser_top.sv
// ----------------------------------------------------------------------------
// vorbis_id_header_parser_top
// Header packet parser, one byte per beat, one result beat per packet.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one packet byte per beat in tdata; tlast marks the final
//   byte of the packet. m_axis carries one beat per packet: tuser holds the
//   packet kind, tdata the check status and the identification fields.
//   Non-identification and short packets return zeros in the field bits.
//   Throughput is one byte per cycle while no last byte is held, set by the
//   single register-to-register pass through the field and check logic. A
//   last byte passes through the input register and then the result
//   register, which drives m_axis_tvalid; it waits in the input register
//   while a stalled result beat still occupies the result register.
//   Bytes past position 29 are dropped; the position counter saturates at 31.
//   Reset clears the position and field registers, sets the magic match
//   flag and empties both register stages. While a result beat waits on
//   m_axis_tready, body bytes keep flowing; only a last byte holds in the
//   input register, which then backpressures s_axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vorbis_id_header_parser_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] data_byte
  input  logic                            s_axis_tlast,   // last_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [2:0] status, [34:3] stream_version, [42:35] channels,
  // [74:43] audio_rate, [106:75] bitrate_max, [138:107] bitrate_nom,
  // [170:139] bitrate_min, [174:171] block_exp_small,
  // [178:175] block_exp_large, [183:179] zero
  output logic [vip_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [vip_pkg::OUT_TUSER_W-1:0] m_axis_tuser    // [1:0] packet_kind
);

  logic             in_valid;
  vip_pkg::beat_t   beat;
  vip_pkg::fields_t fields;
  logic             out_free;
  logic             take;
  logic             load;

  // A last byte waits until the result register can take its beat
  assign take = in_valid && (!beat.last || out_free);
  assign load = take && beat.last;

  vip_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .take_i        (take),
    .valid_o       (in_valid),
    .beat_o        (beat)
  );

  vip_fields u_fields (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (take),
    .beat_i   (beat),
    .fields_o (fields)
  );

  vip_result u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .fields_i      (fields),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### rtl/vip_checker.sv
// ----------------------------------------------------------------------------
// vip_checker
// Port-level checks on the parser's result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vip_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [vip_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [vip_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  logic stalled;
  logic is_ident;
  logic bad_magic;

  assign stalled   = m_axis_tvalid && !m_axis_tready;
  assign is_ident  = (m_axis_tuser == vip_pkg::KIND_IDENT);
  assign bad_magic = (m_axis_tdata[2:0] == vip_pkg::ST_BAD_MAGIC);

  // stalled result beat holds
  `VIP_ASSERT_NXT(a_hold, clk_i, rst_ni, stalled, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // only identification packets get a status other than bad magic
  `VIP_ASSERT_IMP(a_kind_status, clk_i, rst_ni, m_axis_tvalid && !is_ident, bad_magic)
  // fields are zero unless the packet is an identification header
  `VIP_ASSERT_IMP(a_zero_fields, clk_i, rst_ni, m_axis_tvalid && !is_ident, m_axis_tdata[178:3] == '0)
  // pad bits above the last field stay zero
  `VIP_ASSERT_IMP(a_pad, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[183:179] == '0)

endmodule

bind vorbis_id_header_parser_top vip_checker u_vip_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
